### rtl/core/rfpu_pkg.sv
// Shared types, register codes and sample decode function for the raw frame pixel unpacker.
package rfpu_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int DEPTH_W    = 5;
    localparam int PPF_W      = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;
    localparam int PROD_W     = 32;
    localparam int SUM_W      = 33;

    // Q0.16 luma weights for .299 / .587 / .114
    localparam logic [15:0] W_RED   = 16'd19595;
    localparam logic [15:0] W_GREEN = 16'd38470;
    localparam logic [15:0] W_BLUE  = 16'd7471;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THREE_PLANES = 3'd0,
        CFG_PIXEL_DEPTH  = 3'd1,
        CFG_CAMERA_BITS  = 3'd2,
        CFG_GREY_RGB     = 3'd3,
        CFG_BGR_ORDER    = 3'd4,
        CFG_PIX_PER_FRM  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic               three_planes;
        logic [DEPTH_W-1:0] pixel_depth;
        logic [DEPTH_W-1:0] camera_bits;
        logic               grey_from_rgb;
        logic               bgr_order;
        logic [PPF_W-1:0]   pixels_per_frame;
    } t_cfg;

    // One complete pixel's raw samples, handed from gather to conversion
    typedef struct packed {
        logic [SAMPLE_W-1:0] raw0;
        logic [SAMPLE_W-1:0] raw1;
        logic [SAMPLE_W-1:0] raw2;
        logic                luma;
        logic                last;
    } t_job;

    // Mask narrow samples to 8 bits, shift wide samples down to camera bits
    function automatic logic [SAMPLE_W-1:0] decode_sample(
        input logic [SAMPLE_W-1:0] raw,
        input logic [DEPTH_W-1:0]  depth,
        input logic [DEPTH_W-1:0]  cam
    );
        logic [DEPTH_W-1:0]  cb;
        logic [DEPTH_W-1:0]  sh;
        logic [SAMPLE_W-1:0] res;
        cb = (cam == '0) ? depth : cam;
        sh = depth - cb;
        if (depth <= DEPTH_W'(8)) begin
            res = {8'd0, raw[7:0]};
        end else if (depth <= cb) begin
            res = raw;
        end else if (sh >= DEPTH_W'(16)) begin
            res = '0;
        end else begin
            res = raw >> sh[3:0];
        end
        return res;
    endfunction

endpackage

### rtl/core/rfpu_if.sv
// Handshake channel interfaces: sample input, pixel output and register write.
interface rfpu_sample_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface rfpu_pixel_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel;
    logic        last_in_frame;
    modport source (output valid, output pixel, output last_in_frame, input ready);
    modport sink   (input valid, input pixel, input last_in_frame, output ready);
endinterface

interface rfpu_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [24:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/rfpu_cfg.sv
// Configuration register file with index decode.
module rfpu_cfg
    import rfpu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_valid,
    input  logic [CFG_IDX_W-1:0]  i_wr_index,
    input  logic [CFG_DATA_W-1:0] i_wr_data,
    output logic                  o_wr_ready,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_wr_ready = 1'b1;
    assign o_cfg      = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_valid) begin
            unique case (t_cfg_idx'(i_wr_index))
                CFG_THREE_PLANES: n_cfg.three_planes     = i_wr_data[0];
                CFG_PIXEL_DEPTH:  n_cfg.pixel_depth      = i_wr_data[DEPTH_W-1:0];
                CFG_CAMERA_BITS:  n_cfg.camera_bits      = i_wr_data[DEPTH_W-1:0];
                CFG_GREY_RGB:     n_cfg.grey_from_rgb    = i_wr_data[0];
                CFG_BGR_ORDER:    n_cfg.bgr_order        = i_wr_data[0];
                CFG_PIX_PER_FRM:  n_cfg.pixels_per_frame = i_wr_data[PPF_W-1:0];
                default:          n_cfg                  = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.three_planes     <= 1'b0;
            r_cfg.pixel_depth      <= DEPTH_W'(8);
            r_cfg.camera_bits      <= '0;
            r_cfg.grey_from_rgb    <= 1'b0;
            r_cfg.bgr_order        <= 1'b0;
            r_cfg.pixels_per_frame <= PPF_W'(1);
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

### rtl/core/rfpu_gather.sv
// Input register stage: plane gathering, sample holds and frame pixel counter.
module rfpu_gather
    import rfpu_pkg::*;
#(
    parameter int PIXEL_COUNT_BITS = 25
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_valid,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                o_ready,
    output logic                o_job_valid,
    output t_job                o_job,
    input  logic                i_job_ready
);

    localparam int CMP_W = (PIXEL_COUNT_BITS > PPF_W) ? PIXEL_COUNT_BITS : PPF_W;

    logic [1:0]                  r_plane;
    logic [1:0]                  n_plane;
    logic [SAMPLE_W-1:0]         r_hold0;
    logic [SAMPLE_W-1:0]         r_hold1;
    logic [PIXEL_COUNT_BITS-1:0] r_count;
    logic [PIXEL_COUNT_BITS-1:0] n_count;
    logic                        r_vld;
    t_job                        r_job;
    t_job                        n_job;
    logic                        accept;
    logic                        emit;
    logic [PPF_W-1:0]            ppf_eff;
    logic                        at_last;

    assign o_ready     = !r_vld || i_job_ready;
    assign accept      = i_valid && o_ready;
    assign o_job_valid = r_vld;
    assign o_job       = r_job;

    // Zero pixels per frame counts as one
    assign ppf_eff = (i_cfg.pixels_per_frame == '0) ? PPF_W'(1) : i_cfg.pixels_per_frame;
    assign at_last = (CMP_W'(r_count) == CMP_W'(ppf_eff - PPF_W'(1)));
    assign n_count = at_last ? '0 : r_count + PIXEL_COUNT_BITS'(1);

    always_comb begin
        emit       = 1'b0;
        n_plane    = r_plane;
        n_job.raw0 = i_sample;
        n_job.raw1 = r_hold1;
        n_job.raw2 = i_sample;
        n_job.luma = 1'b0;
        n_job.last = at_last;
        if (!i_cfg.three_planes) begin
            emit    = 1'b1;
            n_plane = 2'd0;
        end else if (r_plane == 2'd0) begin
            n_plane = 2'd1;
        end else if (r_plane == 2'd1) begin
            n_plane = 2'd2;
        end else begin
            emit       = 1'b1;
            n_plane    = 2'd0;
            n_job.raw0 = r_hold0;
            n_job.luma = i_cfg.grey_from_rgb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '0;
            r_hold0 <= '0;
            r_hold1 <= '0;
            r_count <= '0;
            r_vld   <= 1'b0;
        end else begin
            if (accept && emit) begin
                r_vld <= 1'b1;
            end else if (i_job_ready) begin
                r_vld <= 1'b0;
            end
            if (accept) begin
                r_plane <= n_plane;
                if (i_cfg.three_planes && r_plane == 2'd0) begin
                    r_hold0 <= i_sample;
                end
                if (i_cfg.three_planes && r_plane == 2'd1) begin
                    r_hold1 <= i_sample;
                end
                if (emit) begin
                    r_count <= n_count;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_job <= n_job;
        end
    end

endmodule

### rtl/core/rfpu_luma.sv
// Decode, luma weighting and sum into the output register.
module rfpu_luma
    import rfpu_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_job_valid,
    input  t_job                i_job,
    output logic                o_job_ready,
    output logic                o_valid,
    output logic [SAMPLE_W-1:0] o_pixel,
    output logic                o_last,
    input  logic                i_ready
);

    logic                r_vld;
    logic [SAMPLE_W-1:0] r_pixel;
    logic                r_last;
    logic                ready;
    logic [SAMPLE_W-1:0] p0;
    logic [SAMPLE_W-1:0] p1;
    logic [SAMPLE_W-1:0] p2;
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] blue;
    logic [PROD_W-1:0]   prod_r;
    logic [PROD_W-1:0]   prod_g;
    logic [PROD_W-1:0]   prod_b;
    logic [SUM_W-1:0]    sum;
    logic [SAMPLE_W-1:0] n_pixel;

    assign ready       = !r_vld || i_ready;
    assign o_job_ready = ready;
    assign o_valid     = r_vld;
    assign o_pixel     = r_pixel;
    assign o_last      = r_last;

    assign p0   = decode_sample(i_job.raw0, i_cfg.pixel_depth, i_cfg.camera_bits);
    assign p1   = decode_sample(i_job.raw1, i_cfg.pixel_depth, i_cfg.camera_bits);
    assign p2   = decode_sample(i_job.raw2, i_cfg.pixel_depth, i_cfg.camera_bits);
    assign red  = i_cfg.bgr_order ? p2 : p0;
    assign blue = i_cfg.bgr_order ? p0 : p2;

    assign prod_r  = red * W_RED;
    assign prod_g  = p1 * W_GREEN;
    assign prod_b  = blue * W_BLUE;
    assign sum     = SUM_W'(prod_r) + SUM_W'(prod_g) + SUM_W'(prod_b);
    assign n_pixel = i_job.luma ? sum[SAMPLE_W+15:16] : p0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (ready) begin
            r_vld <= i_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready && i_job_valid) begin
            r_pixel <= n_pixel;
            r_last  <= i_job.last;
        end
    end

endmodule

### rtl/core/raw_frame_pixel_unpacker_top.sv
// Top level of the raw frame pixel unpacker: channels, config registers, pipeline.
//
// Usage:
//   i_sample_ch  - raw plane samples, one per transfer (valid/ready).
//   o_pixel_ch   - one pixel per transfer with a last_in_frame flag.
//   i_cfg_ch     - register writes (index, data); always ready, write only
//                  while the pipeline is empty.
// In mono mode every sample makes a pixel; in three-plane mode every third
// sample completes a pixel (first plane sample or luma of all three).
// Path: a completing sample's pixel passes the gather register, then the
// output register, before it is on o_pixel_ch and can transfer.
// Throughput: one sample per cycle; the pipeline advances whenever the
// output register is empty or being taken.
// Stall: when the receiver holds ready low, the output register holds its
// pixel and the gather register fills behind it; with two pixels in flight
// i_sample_ch.ready drops until the receiver takes the output.
// Reset (synchronous, active low): empty the pipeline, clear plane index,
// sample holds and pixel counter, and load register defaults (mono, depth 8,
// camera bits 0, one pixel per frame).
module raw_frame_pixel_unpacker_top
    import rfpu_pkg::*;
#(
    parameter int PIXEL_COUNT_BITS = 25
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rfpu_sample_if.sink  i_sample_ch,
    rfpu_pixel_if.source o_pixel_ch,
    rfpu_cfg_if.sink     i_cfg_ch
);

    t_cfg cfg;
    t_job job;
    logic job_valid;
    logic job_ready;

    // Register file
    rfpu_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg_ch.valid),
        .i_wr_index (i_cfg_ch.index),
        .i_wr_data  (i_cfg_ch.data),
        .o_wr_ready (i_cfg_ch.ready),
        .o_cfg      (cfg)
    );

    // Gather planes and count pixels into a job register
    rfpu_gather #(
        .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
    ) u_gather (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (i_sample_ch.valid),
        .i_sample    (i_sample_ch.sample),
        .o_ready     (i_sample_ch.ready),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_ready (job_ready)
    );

    // Decode, weight and sum into the output register
    rfpu_luma u_luma (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_ready (job_ready),
        .o_valid     (o_pixel_ch.valid),
        .o_pixel     (o_pixel_ch.pixel),
        .o_last      (o_pixel_ch.last_in_frame),
        .i_ready     (o_pixel_ch.ready)
    );

endmodule

### rtl/core/rfpu_checker.sv
// Port-level checker for the raw frame pixel unpacker, bound to the top level.
module rfpu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_pixel,
    input logic        i_out_last
);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // An empty output register implies the whole pipeline can take a sample
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while output empty");

    // Stalled output holds its pixel
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_pixel) && $stable(i_out_last))
        else $error("output changed while stalled");

endmodule

bind raw_frame_pixel_unpacker_top rfpu_checker u_rfpu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_sample_ch.ready),
    .i_out_valid (o_pixel_ch.valid),
    .i_out_ready (o_pixel_ch.ready),
    .i_out_pixel (o_pixel_ch.pixel),
    .i_out_last  (o_pixel_ch.last_in_frame)
);

### dv/tb.sv
// Self-checking testbench for the raw frame pixel unpacker: directed table, then random segments.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rfpu_pkg::*;

    localparam int LATENCY_CYCLES = 2;
    localparam int SETTLE_CYCLES  = LATENCY_CYCLES + 3;
    localparam int TAIL_CYCLES    = 4 * LATENCY_CYCLES + 8;
    localparam int RANDOM_ITEMS   = 1600;
    localparam int QUIET_ITEMS    = 300;
    localparam int CYCLE_LIMIT    = 400000;

    // Q0.16 luma weights
    localparam longint LUMA_R = 19595;
    localparam longint LUMA_G = 38470;
    localparam longint LUMA_B = 7471;

    typedef enum logic {ROW_CFG, ROW_SAMPLE} t_row_kind;

    typedef struct {
        logic [15:0] pixel;
        logic        last;
    } t_pixel_exp;

    // One directed step: either a register write or a sample; a sample row may
    // carry a hand-typed expectation that replaces the predicted one.
    typedef struct {
        t_row_kind   kind;
        t_cfg_idx    reg_idx;
        logic [24:0] value;
        logic [15:0] sample;
        bit          has_want;
        logic [15:0] want_pix;
        bit          want_last;
    } t_stim_row;

    localparam int N_ROWS = 42;

    t_stim_row directed_rows [N_ROWS] = '{
        // reset defaults: mono, 8-bit samples, one pixel per frame
        '{ROW_SAMPLE, CFG_THREE_PLANES, 25'd0,  16'hFFFF, 1'b1, 16'h00FF, 1'b1},
        '{ROW_SAMPLE, CFG_THREE_PLANES, 25'd0,  16'hA5C3, 1'b1, 16'h00C3, 1'b1},
        // 16-bit samples, no shift, then shift by 6, then shift past the width
        '{ROW_CFG,    CFG_PIXEL_DEPTH,  25'd16, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, CFG_THREE_PLANES, 25'd0,  16'hFFFF, 1'b1, 16'hFFFF, 1'b1},
        '{ROW_CFG,    CFG_CAMERA_BITS,  25'd10, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, CFG_THREE_PLANES, 25'd0,  16'hFFFF, 1'b1, 16'h03FF, 1'b1},
        '{ROW_CFG,    CFG_PIXEL_DEPTH,  25'd31, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, CFG_THREE_PLANES, 25'd0,  16'hFFFF, 1'b1, 16'h0000, 1'b1},
        // depth zero acts as 8-bit, zero pixels per frame acts as one
        '{ROW_CFG,    CFG_PIXEL_DEPTH,  25'd0,  16'h0000, 1'b0, 16'h0000, 1'b0},
        '{ROW_CFG,    CFG_PIX_PER_FRM,  25'd0,  16'h0000, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, CFG_THREE_PLANES, 25'd0,  16'h1234, 1'b1, 16'h0034, 1'b1},
        // two-pixel frames, 12-bit samples
        '{ROW_CFG,    CFG_PIX_PER_FRM,  25'd2,  16'h0000, 1'b0, 16'h0000, 1'b0},
        '{ROW_CFG,    CFG_PIXEL_DEPTH,  25'd12, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{ROW_CFG,    CFG_CAMERA_BITS,  25'd0,  16'h0000, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, CFG_THREE_PLANES, 25'd0,  16'h0ABC, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, CFG_THREE_PLANES, 25'd0,  16'hF000, 1'b0, 16'h0000, 1'b0},
        // three planes, first plane passed through
        '{ROW_CFG,    CFG_THREE_PLANES, 25'd1,  16'h0000, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, CFG_THREE_PLANES, 25'd0,  16'h8001, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, CFG_THREE_PLANES, 25'd0,  16'h7FFE, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, CFG_THREE_PLANES, 25'd0,  16'h0000, 1'b0, 16'h0000, 1'b0},
        // luma of full-scale white is full scale, and closes the frame
        '{ROW_CFG,    CFG_GREY_RGB,     25'd1,  16'h0000, 1'b0, 16'h0000, 1'b0},
        '{ROW_CFG,    CFG_PIXEL_DEPTH,  25'd8,  16'h0000, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, CFG_THREE_PLANES, 25'd0,  16'h00FF, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, CFG_THREE_PLANES, 25'd0,  16'h00FF, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, CFG_THREE_PLANES, 25'd0,  16'h00FF, 1'b1, 16'h00FF, 1'b1},
        // blue first: pure blue gives the small blue weight only
        '{ROW_CFG,    CFG_PIX_PER_FRM,  25'd1,  16'h0000, 1'b0, 16'h0000, 1'b0},
        '{ROW_CFG,    CFG_BGR_ORDER,    25'd1,  16'h0000, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, CFG_THREE_PLANES, 25'd0,  16'h00FF, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, CFG_THREE_PLANES, 25'd0,  16'h0000, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, CFG_THREE_PLANES, 25'd0,  16'h0000, 1'b0, 16'h0000, 1'b0},
        // register write between planes: held samples decode with the new shift
        '{ROW_CFG,    CFG_PIXEL_DEPTH,  25'd16, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, CFG_THREE_PLANES, 25'd0,  16'h1234, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, CFG_THREE_PLANES, 25'd0,  16'h5678, 1'b0, 16'h0000, 1'b0},
        '{ROW_CFG,    CFG_CAMERA_BITS,  25'd8,  16'h0000, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, CFG_THREE_PLANES, 25'd0,  16'h9ABC, 1'b0, 16'h0000, 1'b0},
        // drop to mono in the middle of a pixel, then back to three planes
        '{ROW_SAMPLE, CFG_THREE_PLANES, 25'd0,  16'h4321, 1'b0, 16'h0000, 1'b0},
        '{ROW_CFG,    CFG_THREE_PLANES, 25'd0,  16'h0000, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, CFG_THREE_PLANES, 25'd0,  16'h00AA, 1'b0, 16'h0000, 1'b0},
        '{ROW_CFG,    CFG_THREE_PLANES, 25'd1,  16'h0000, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, CFG_THREE_PLANES, 25'd0,  16'h1111, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, CFG_THREE_PLANES, 25'd0,  16'h2222, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, CFG_THREE_PLANES, 25'd0,  16'h3333, 1'b0, 16'h0000, 1'b0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    rfpu_sample_if smp_ch ();
    rfpu_pixel_if  pix_ch ();
    rfpu_cfg_if    cfg_ch ();

    raw_frame_pixel_unpacker_top #(
        .PIXEL_COUNT_BITS(25)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_ch (smp_ch),
        .o_pixel_ch  (pix_ch),
        .i_cfg_ch    (cfg_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow of the block: register copy plus plane gather and frame position
    t_cfg        shadow_cfg;
    logic [1:0]  plane_pos;
    logic [15:0] held_first;
    logic [15:0] held_second;
    logic [24:0] frame_pos;

    t_pixel_exp  expected_pixels [$];
    t_pixel_exp  next_want;

    int err_count      = 0;
    int samples_sent   = 0;
    int pixels_checked = 0;
    int cfg_writes     = 0;
    int luma_pixels    = 0;
    int frame_ends     = 0;
    int cycle_count    = 0;
    int stall_left     = 0;
    int tx_gap_pct     = 10;
    int rx_stall_pct   = 5;
    bit quiet          = 1'b0;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        err_count++;
        $display("[%0t] pixel %0d: %s got %h want %h", $realtime, pixels_checked,
                 what, got, want);
    endtask

    // Narrow samples keep their low byte; wide samples drop down to camera bits
    function automatic logic [15:0] scale_sample(input logic [15:0] raw);
        int target;
        int drop;
        if (shadow_cfg.pixel_depth <= 5'd8)
            return {8'h00, raw[7:0]};
        target = (shadow_cfg.camera_bits == '0) ? int'(shadow_cfg.pixel_depth)
                                                : int'(shadow_cfg.camera_bits);
        drop = int'(shadow_cfg.pixel_depth) - target;
        if (drop <= 0)
            return raw;
        if (drop >= 16)
            return '0;
        return raw >> drop;
    endfunction

    // Advance the shadow by one sample; emit tells whether a pixel comes out
    function automatic void unpack_pixel(input logic [15:0] s, output bit emit,
                                         output t_pixel_exp px);
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        longint      acc;
        longint      frame_len;
        emit     = 1'b1;
        px.pixel = '0;
        px.last  = 1'b0;
        if (!shadow_cfg.three_planes) begin
            plane_pos = 2'd0;
            px.pixel  = scale_sample(s);
        end else if (plane_pos == 2'd0) begin
            held_first = s;
            plane_pos  = 2'd1;
            emit       = 1'b0;
        end else if (plane_pos == 2'd1) begin
            held_second = s;
            plane_pos   = 2'd2;
            emit        = 1'b0;
        end else begin
            plane_pos = 2'd0;
            if (shadow_cfg.grey_from_rgb) begin
                red   = scale_sample(shadow_cfg.bgr_order ? s : held_first);
                blue  = scale_sample(shadow_cfg.bgr_order ? held_first : s);
                green = scale_sample(held_second);
                acc   = LUMA_R * red + LUMA_G * green + LUMA_B * blue;
                px.pixel = 16'(acc >> 16);
                luma_pixels++;
            end else begin
                px.pixel = scale_sample(held_first);
            end
        end
        if (emit) begin
            frame_len = (shadow_cfg.pixels_per_frame == '0) ? 1
                                                           : longint'(shadow_cfg.pixels_per_frame);
            if (longint'(frame_pos) == frame_len - 1) begin
                frame_pos = '0;
                px.last   = 1'b1;
            end else begin
                frame_pos = frame_pos + 1'b1;
            end
        end
    endfunction

    // Drop valid, wait for every pending pixel, then let the pipeline empty
    task automatic settle();
        smp_ch.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register writes only land on an idle block
    task automatic cfg_write(input t_cfg_idx idx, input logic [24:0] value);
        settle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do begin
            @(posedge i_clk);
        end while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_THREE_PLANES: shadow_cfg.three_planes     = value[0];
            CFG_PIXEL_DEPTH:  shadow_cfg.pixel_depth      = value[4:0];
            CFG_CAMERA_BITS:  shadow_cfg.camera_bits      = value[4:0];
            CFG_GREY_RGB:     shadow_cfg.grey_from_rgb    = value[0];
            CFG_BGR_ORDER:    shadow_cfg.bgr_order        = value[0];
            CFG_PIX_PER_FRM:  shadow_cfg.pixels_per_frame = value;
            default: ;
        endcase
        cfg_writes++;
    endtask

    // Send one sample, with an optional idle burst ahead of it; valid stays
    // high after the transfer so back-to-back samples need no re-raise.
    task automatic push_sample(input logic [15:0] s, input bit has_want,
                               input t_pixel_exp want);
        int         gap;
        bit         emit;
        t_pixel_exp px;
        gap = 0;
        if (!quiet && tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct)
            gap = $urandom_range(15, 1);
        if (gap > 0) begin
            smp_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_ch.valid  <= 1'b1;
        smp_ch.sample <= s;
        do begin
            @(posedge i_clk);
        end while (!smp_ch.ready);
        unpack_pixel(s, emit, px);
        if (emit)
            expected_pixels.push_back(has_want ? want : px);
        samples_sent++;
    endtask

    // Receiver: check each pixel transfer, then pick ready for the next cycle
    initial begin
        pix_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("unexpected pixel", pix_ch.pixel, 16'h0000);
                end else begin
                    next_want = expected_pixels.pop_front();
                    if (pix_ch.pixel !== next_want.pixel)
                        report_mismatch("pixel", pix_ch.pixel, next_want.pixel);
                    if (pix_ch.last_in_frame !== next_want.last)
                        report_mismatch("last_in_frame", 16'(pix_ch.last_in_frame),
                                        16'(next_want.last));
                    if (next_want.last)
                        frame_ends++;
                    pixels_checked++;
                end
            end
            // hold a stall burst, maybe start one, otherwise take pixels
            if (stall_left > 0) begin
                stall_left--;
                pix_ch.ready <= 1'b0;
            end else if (!quiet && rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct) begin
                stall_left = $urandom_range(15, 1) - 1;
                pix_ch.ready <= 1'b0;
            end else begin
                pix_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d pixels outstanding", cycle_count,
                 expected_pixels.size());
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int          random_sent;
        int          seg_items;
        int          pick;
        logic [15:0] smp;
        t_pixel_exp  no_want;

        random_sent = 0;
        no_want     = '{16'h0000, 1'b0};

        smp_ch.valid  <= 1'b0;
        smp_ch.sample <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= CFG_THREE_PLANES;
        cfg_ch.data   <= '0;
        i_rst_n       <= 1'b0;

        // shadow mirrors the reset state of the block
        shadow_cfg.three_planes     = 1'b0;
        shadow_cfg.pixel_depth      = 5'd8;
        shadow_cfg.camera_bits      = 5'd0;
        shadow_cfg.grey_from_rgb    = 1'b0;
        shadow_cfg.bgr_order        = 1'b0;
        shadow_cfg.pixels_per_frame = 25'd1;
        plane_pos   = 2'd0;
        held_first  = '0;
        held_second = '0;
        frame_pos   = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                cfg_write(directed_rows[i].reg_idx, directed_rows[i].value);
            end else begin
                push_sample(directed_rows[i].sample, directed_rows[i].has_want,
                            '{directed_rows[i].want_pix, directed_rows[i].want_last});
            end
        end

        // Random segments: new settings, then a run of samples that mostly
        // finishes whole pixels; the final segments go without idling.
        while (random_sent < RANDOM_ITEMS) begin
            quiet = (random_sent >= RANDOM_ITEMS - QUIET_ITEMS);
            case ($urandom_range(2))
                0:       tx_gap_pct = 0;
                1:       tx_gap_pct = 10;
                default: tx_gap_pct = 30;
            endcase
            case ($urandom_range(2))
                0:       rx_stall_pct = 0;
                1:       rx_stall_pct = 5;
                default: rx_stall_pct = 20;
            endcase

            if ($urandom_range(1))
                cfg_write(CFG_THREE_PLANES, 25'($urandom_range(1)));
            if ($urandom_range(1)) begin
                case ($urandom_range(3))
                    0:       pick = $urandom_range(8, 1);
                    1:       pick = $urandom_range(16, 9);
                    2:       pick = 16;
                    default: pick = $urandom_range(31, 0);
                endcase
                cfg_write(CFG_PIXEL_DEPTH, 25'(pick));
            end
            if ($urandom_range(1))
                cfg_write(CFG_CAMERA_BITS,
                          ($urandom_range(2) == 0) ? 25'd0 : 25'($urandom_range(31, 0)));
            if ($urandom_range(2) == 0)
                cfg_write(CFG_GREY_RGB, 25'($urandom_range(1)));
            if ($urandom_range(2) == 0)
                cfg_write(CFG_BGR_ORDER, 25'($urandom_range(1)));
            if ($urandom_range(1)) begin
                // keep the frame length past the current position so frames
                // keep closing; long frames only now and then
                case ($urandom_range(5))
                    0:       pick = (frame_pos == '0) ? 0 : int'(frame_pos) + 1;
                    1:       pick = int'($urandom & 32'h01FF_FFFF);
                    2:       pick = 32'h01FF_FFFF;
                    default: pick = int'(frame_pos) + $urandom_range(8, 1);
                endcase
                if (pick != 0 && pick <= int'(frame_pos))
                    pick = int'(frame_pos) + 1;
                cfg_write(CFG_PIX_PER_FRM, 25'(pick));
            end

            seg_items = $urandom_range(120, 30);
            if (shadow_cfg.three_planes && $urandom_range(4) != 0)
                seg_items = seg_items - seg_items % 3 + (3 - int'(plane_pos)) % 3;
            repeat (seg_items) begin
                case ($urandom_range(9))
                    0:       smp = 16'h0000;
                    1:       smp = 16'hFFFF;
                    2, 3:    smp = 16'($urandom_range(255));
                    default: smp = 16'($urandom);
                endcase
                push_sample(smp, 1'b0, no_want);
                random_sent++;
            end
        end

        // Drain, then give stray pixels time to show up
        smp_ch.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run: %0d samples in, %0d pixels checked (%0d luma), %0d frames closed",
                 samples_sent, pixels_checked, luma_pixels, frame_ends);
        $display("Run: %0d register writes across mono/three-plane, depths and shifts, %0d errors",
                 cfg_writes, err_count);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
